// File: design/uscd_pkg.sv
package uscd_pkg;

    localparam int unsigned SECS_W   = 32;
    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned BIT_W    = 4;
    localparam int unsigned OUT_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
    localparam int unsigned M_DATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [SECS_W-1:0]  SECS_PER_MIN  = 32'd60;
    localparam logic [SECS_W-1:0]  SECS_PER_HOUR = 32'd3600;
    localparam logic [SECS_W-1:0]  SECS_PER_DAY  = 32'd86400;
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
    localparam logic [YEAR_W-1:0]  NONLEAP_CENT  = 12'd2100;
    localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd11;

    localparam logic [BIT_W-1:0] DAY_TOP_BIT  = 4'd15;
    localparam logic [BIT_W-1:0] HOUR_TOP_BIT = 4'd4;
    localparam logic [BIT_W-1:0] MIN_TOP_BIT  = 4'd5;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_DAY   = 3'd2;
    localparam logic [2:0] OP_HOUR  = 3'd3;
    localparam logic [2:0] OP_MIN   = 3'd4;
    localparam logic [2:0] OP_YEAR  = 3'd5;
    localparam logic [2:0] OP_MONTH = 3'd6;

    typedef struct packed {
        logic [2:0]       op;
        logic [BIT_W-1:0] bit_idx;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_free;
    } t_sts;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd1:                      len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: design/unix_seconds_to_calendar_date.sv
// from accept to o_m_tvalid: 16 + 5 + 6 shift-subtract steps for days, hours and minutes,
// then a year search and a month search, each stepping one year or month at a time and
// ending once its check sees the search done, and then the load of the output register
// a new word is not taken until the current one is handed to the output register, so a
// stalled output adds its wait
// reset: i_rst_n synchronous active low clears the controller and output valid
module unix_seconds_to_calendar_date
    import uscd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [SECS_W-1:0]   i_s_tdata,  // unix_seconds
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata   // year_value, month_value, day_of_month,
                                            // hour_of_day, minute_of_hour, second_of_minute
);

    t_cmd cmd;
    t_sts sts;

    uscd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    uscd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_secs      (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule

// File: design/uscd_ctrl.sv
module uscd_ctrl
    import uscd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DAY   = 3'd1;
    localparam logic [2:0] ST_HOUR  = 3'd2;
    localparam logic [2:0] ST_MIN   = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_bit         = r_bit;
        o_in_ready    = 1'b0;
        o_cmd.op      = OP_NONE;
        o_cmd.bit_idx = r_bit;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DAY;
                    n_bit    = DAY_TOP_BIT;
                end
            end
            ST_DAY: begin
                o_cmd.op = OP_DAY;
                if (r_bit == '0) begin
                    n_state = ST_HOUR;
                    n_bit   = HOUR_TOP_BIT;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            ST_HOUR: begin
                o_cmd.op = OP_HOUR;
                if (r_bit == '0) begin
                    n_state = ST_MIN;
                    n_bit   = MIN_TOP_BIT;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            ST_MIN: begin
                o_cmd.op = OP_MIN;
                if (r_bit == '0) begin
                    n_state = ST_YEAR;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            ST_YEAR: begin
                o_cmd.op = OP_YEAR;
                if (i_sts.year_done) begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                o_cmd.op = OP_MONTH;
                if (i_sts.month_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/uscd_dp.sv
module uscd_dp
    import uscd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [SECS_W-1:0]   i_secs,
    input  logic                i_out_ready,
    output t_sts                o_sts,
    output logic                o_out_valid,
    output logic [M_DATA_W-1:0] o_out_data
);

    logic [SECS_W-1:0]   r_rem, n_rem;
    logic [DAYS_W-1:0]   r_days, n_days;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [HOUR_W-1:0]   r_hour, n_hour;
    logic [MIN_W-1:0]    r_min, n_min;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic [SECS_W-1:0] dvs;
    logic [SECS_W-1:0] diff;
    logic              ge;
    logic              leap;
    logic [8:0]        ylen;
    logic [DAY_W-1:0]  mlen;
    logic              year_done;
    logic              month_done;
    logic [DAY_W-1:0]  day_out;
    logic [MONTH_W-1:0] month_out;

    always_comb begin
        unique case (i_cmd.op)
            OP_DAY:  dvs = SECS_PER_DAY << i_cmd.bit_idx;
            OP_HOUR: dvs = SECS_PER_HOUR << i_cmd.bit_idx;
            default: dvs = SECS_PER_MIN << i_cmd.bit_idx;
        endcase
        ge         = r_rem >= dvs;
        diff       = r_rem - dvs;
        leap       = (r_year[1:0] == 2'b00) && (r_year != NONLEAP_CENT);
        ylen       = leap ? 9'd366 : 9'd365;
        mlen       = month_len(r_month, leap);
        year_done  = r_days < DAYS_W'(ylen);
        month_done = (r_month == LAST_MONTH) || (r_days < DAYS_W'(mlen));
        day_out    = r_days[DAY_W-1:0] + 5'd1;
        month_out  = r_month + 4'd1;
    end

    always_comb begin
        n_rem   = r_rem;
        n_days  = r_days;
        n_year  = r_year;
        n_month = r_month;
        n_hour  = r_hour;
        n_min   = r_min;
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                n_rem   = i_secs;
                n_days  = '0;
                n_year  = EPOCH_YEAR;
                n_month = '0;
                n_hour  = '0;
                n_min   = '0;
            end
            OP_DAY: begin
                if (ge) begin
                    n_rem  = diff;
                    n_days = r_days | (DAYS_W'(1) << i_cmd.bit_idx);
                end
            end
            OP_HOUR: begin
                if (ge) begin
                    n_rem  = diff;
                    n_hour = r_hour | (HOUR_W'(1) << i_cmd.bit_idx);
                end
            end
            OP_MIN: begin
                if (ge) begin
                    n_rem = diff;
                    n_min = r_min | (MIN_W'(1) << i_cmd.bit_idx);
                end
            end
            OP_YEAR: begin
                if (!year_done) begin
                    n_days = r_days - DAYS_W'(ylen);
                    n_year = r_year + 12'd1;
                end
            end
            OP_MONTH: begin
                if (!month_done) begin
                    n_days  = r_days - DAYS_W'(mlen);
                    n_month = r_month + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_days  <= n_days;
        r_year  <= n_year;
        r_month <= n_month;
        r_hour  <= n_hour;
        r_min   <= n_min;
        if (i_cmd.emit) begin
            r_out_data <= {{(M_DATA_W - OUT_W){1'b0}}, r_rem[SEC_W-1:0], r_min, r_hour,
                           day_out, month_out, r_year};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.year_done  = year_done;
    assign o_sts.month_done = month_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted word not presented");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("emit overwrote a pending word");

    a_year_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_YEAR && !year_done) |=> (r_year == $past(r_year) + 12'd1))
        else $error("year search did not advance");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[15:12] >= 4'd1 && r_out_data[15:12] <= 4'd12))
        else $error("month out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_hour <= 5'd23 && r_min <= 6'd59 && r_rem <= 32'd59))
        else $error("time of day out of range");

endmodule
